// ===== src/ssfl_pkg.sv =====
// shared types and constants for the streaming substring search
// used by ssfl_needle, ssfl_track and substring_search_first_last
`default_nettype none

package ssfl_pkg;

  // width of the reported match position
  localparam int POS_W = 16;

  // word opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_HAY    = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NEEDLE_BIG = 2'd1;
  localparam logic [1:0] ST_HAY_BIG    = 2'd2;

  // needle side status handed to the match tracker
  typedef struct packed {
    logic             hit;       // current haystack byte completes a full match
    logic             empty;     // needle has no bytes
    logic             too_long;  // an append was dropped
    logic [POS_W-1:0] back;      // needle length minus one, low bits
  } ndl_stat_t;

endpackage

`default_nettype wire

// ===== src/ssfl_needle.sv =====
// needle store, needle length and the partial-match shift vector
// depends on ssfl_pkg
`default_nettype none

module ssfl_needle #(
  parameter int MAX_NEEDLE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,       // stage word is consumed this cycle
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        data_byte,
  input  wire logic              hay_full,  // haystack byte would be dropped
  output ssfl_pkg::ndl_stat_t    stat
);
  import ssfl_pkg::*;

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

  logic [7:0]            store_r [MAX_NEEDLE];
  logic [LEN_W-1:0]      len_r;
  logic                  tl_r;
  logic [MAX_NEEDLE-1:0] pm_r;
  logic [MAX_NEEDLE-1:0] pm_nxt;
  logic [MAX_NEEDLE-1:0] eq;
  logic [MAX_NEEDLE-1:0] top;
  logic                  room;

  assign room = (len_r < LEN_W'(MAX_NEEDLE));

  // per-entry compare, masked to the loaded length, plus full-length marker
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      eq[i]  = (store_r[i] == data_byte) && (LEN_W'(i) < len_r);
      top[i] = (len_r == LEN_W'(i + 1));
    end
  end

  assign pm_nxt = ((pm_r << 1) | MAX_NEEDLE'(1)) & eq;

  // status toward the tracker
  always_comb begin
    stat.hit      = |(pm_nxt & top);
    stat.empty    = (len_r == '0);
    stat.too_long = tl_r;
    stat.back     = POS_W'(len_r) - POS_W'(1);
  end

  // needle bytes, written at the current length
  always_ff @(posedge clk) begin
    if (adv && op == OP_APPEND && room) begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
        if (len_r == LEN_W'(i)) begin
          store_r[i] <= data_byte;
        end
      end
    end
  end

  // length, overflow flag and partial-match vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      tl_r  <= 1'b0;
      pm_r  <= '0;
    end else if (adv) begin
      unique case (op)
        OP_CLEAR: begin
          len_r <= '0;
          tl_r  <= 1'b0;
          pm_r  <= '0;
        end
        OP_APPEND: begin
          if (room) begin
            len_r <= len_r + LEN_W'(1);
          end else begin
            tl_r <= 1'b1;
          end
          pm_r <= '0;
        end
        OP_HAY: begin
          if (!hay_full) begin
            pm_r <= pm_nxt;
          end
        end
        default: begin
          pm_r <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ssfl_track.sv =====
// haystack count, match record and the registered result word
// depends on ssfl_pkg
`default_nettype none

module ssfl_track #(
  parameter int MAX_HAYSTACK = 65535
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [1:0]                op,
  input  wire logic                      mode,
  input  wire ssfl_pkg::ndl_stat_t       stat,
  output logic                           hay_full,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_found,
  output logic [ssfl_pkg::POS_W-1:0]     out_position,
  output logic [1:0]                     out_status
);
  import ssfl_pkg::*;

  localparam int CNT_W = $clog2(MAX_HAYSTACK + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             htl_r;
  logic             seen_r;
  logic [POS_W-1:0] mpos_r;
  logic [POS_W-1:0] cnt_lo;
  logic [POS_W-1:0] start;
  logic             vld_r;
  logic             found_r;
  logic [POS_W-1:0] pos_r;
  logic [1:0]       status_r;
  logic             found_nxt;
  logic [POS_W-1:0] pos_nxt;
  logic [1:0]       status_nxt;

  assign hay_full = (cnt_r >= CNT_W'(MAX_HAYSTACK));
  assign cnt_lo   = POS_W'(cnt_r);
  assign start    = cnt_lo - stat.back;

  // haystack count and match record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      htl_r  <= 1'b0;
      seen_r <= 1'b0;
      mpos_r <= '0;
    end else if (adv) begin
      if (op == OP_HAY) begin
        if (hay_full) begin
          htl_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (stat.hit && (mode || !seen_r)) begin
            mpos_r <= start;
            seen_r <= 1'b1;
          end
        end
      end else begin
        cnt_r  <= '0;
        htl_r  <= 1'b0;
        seen_r <= 1'b0;
        mpos_r <= '0;
      end
    end
  end

  // result for an end word
  always_comb begin
    found_nxt  = 1'b0;
    pos_nxt    = '0;
    status_nxt = ST_OK;
    priority if (stat.too_long) begin
      status_nxt = ST_NEEDLE_BIG;
    end else if (htl_r) begin
      status_nxt = ST_HAY_BIG;
    end else if (stat.empty) begin
      found_nxt = 1'b1;
      pos_nxt   = mode ? cnt_lo : '0;
    end else if (seen_r) begin
      found_nxt = 1'b1;
      pos_nxt   = mpos_r;
    end else begin
      found_nxt = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv && op == OP_END) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && op == OP_END) begin
      found_r  <= found_nxt;
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = vld_r;
  assign out_found    = found_r;
  assign out_position = pos_r;
  assign out_status   = status_r;

endmodule

`default_nettype wire

// ===== src/substring_search_first_last.sv =====
// top level of the streaming substring search: input register and hookup
// depends on ssfl_pkg, ssfl_needle and ssfl_track
`default_nettype none

// Streaming substring search. Load a needle with clear and append words, then
// stream haystack bytes and close with an end word; the end word returns one
// result word holding the first or last match start (search_mode 0 or 1), or
// a status for a needle or haystack that overflowed. One word is taken per
// cycle unless the input is held; each word waits in the input register, where
// all needle bytes are compared against it in parallel, and the end word's
// result is registered in the result register as that word moves on. Only an
// end word waiting behind an unread result holds up the input. search_mode is
// to be written only while the block is idle; the block does not enforce this.
module substring_search_first_last #(
  parameter int MAX_NEEDLE   = 16,
  parameter int MAX_HAYSTACK = 65535
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_op,
  input  wire logic [7:0]                in_data_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_found,
  output logic [ssfl_pkg::POS_W-1:0]     out_position,
  output logic [1:0]                     out_status
);
  import ssfl_pkg::*;

  logic        mode_r;
  logic        stg_vld_r;
  logic [1:0]  stg_op_r;
  logic [7:0]  stg_byte_r;
  logic        adv;
  logic        hay_full;
  ndl_stat_t   stat;

  // search mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // stage word moves on unless it is an end word facing a held result
  assign adv      = stg_vld_r && !(stg_op_r == OP_END && out_valid && out_stall);
  assign in_stall = stg_vld_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (!in_stall) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      stg_op_r   <= in_op;
      stg_byte_r <= in_data_byte;
    end
  end

  ssfl_needle #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_needle (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .op        (stg_op_r),
    .data_byte (stg_byte_r),
    .hay_full  (hay_full),
    .stat      (stat)
  );

  ssfl_track #(
    .MAX_HAYSTACK (MAX_HAYSTACK)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .op           (stg_op_r),
    .mode         (mode_r),
    .stat         (stat),
    .hay_full     (hay_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .out_status   (out_status)
  );

  // a found result always carries ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found result with error status");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  // input holds only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && stg_op_r == OP_END)
    else $error("input held without a stalled result");

  // a consumed end word shows a result next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stg_op_r == OP_END |=> out_valid)
    else $error("end word gave no result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the streaming substring search top level
// depends on ssfl_pkg and substring_search_first_last; drives words, predicts and checks results
`default_nettype none

module testbench;
  import ssfl_pkg::*;

  localparam int MAX_NDL     = 16;
  localparam int MAX_HAY     = 65535;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [1:0]       status;
  } search_result_t;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             cfg_wr_en    = 1'b0;
  logic             cfg_wr_data  = 1'b0;
  logic             in_valid     = 1'b0;
  logic [1:0]       in_op        = OP_CLEAR;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_stall    = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             out_found;
  logic [POS_W-1:0] out_position;
  logic [1:0]       out_status;

  // predicted block state
  logic [7:0]  nd_bytes [0:MAX_NDL-1];
  int          nd_len     = 0;
  logic        nd_over    = 1'b0;
  logic [15:0] partial    = '0;
  int          hay_count  = 0;
  logic        hay_over   = 1'b0;
  logic        match_seen = 1'b0;
  int          match_pos  = 0;
  logic        mode       = 1'b0;

  search_result_t pending_answers [$];

  int          fail_count   = 0;
  int          words_sent   = 0;
  int          results_seen = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  logic [5:0]  stall_phase  = '0;
  int          stall_style  = 0;

  substring_search_first_last dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_position (out_position),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // haystack state goes back to empty
  function automatic void clear_haystack();
    partial    = '0;
    hay_count  = 0;
    hay_over   = 1'b0;
    match_seen = 1'b0;
    match_pos  = 0;
  endfunction

  // update the predicted state for one accepted word, queue the answer of an end word
  task automatic predict_search_word(input logic [1:0] op, input logic [7:0] b);
    search_result_t ans;
    logic [15:0]    hits;
    int             i;
    case (op)
      OP_CLEAR: begin
        nd_len  = 0;
        nd_over = 1'b0;
        clear_haystack();
      end
      OP_APPEND: begin
        if (nd_len < MAX_NDL) begin
          nd_bytes[nd_len] = b;
          nd_len++;
        end else begin
          nd_over = 1'b1;
        end
        clear_haystack();
      end
      OP_HAY: begin
        if (hay_count >= MAX_HAY) begin
          hay_over = 1'b1;
        end else begin
          if (nd_len > 0) begin
            hits = '0;
            for (i = 0; i < nd_len; i++)
              if (nd_bytes[i] == b) hits[i] = 1'b1;
            partial = ((partial << 1) | 16'd1) & hits;
            // full match ends here; first mode keeps the earliest one
            if (partial[nd_len-1] && (mode || !match_seen)) begin
              match_pos  = hay_count - (nd_len - 1);
              match_seen = 1'b1;
            end
          end
          hay_count++;
        end
      end
      default: begin
        ans = '0;
        ans.status = ST_OK;
        if (nd_over) begin
          ans.status = ST_NEEDLE_BIG;
        end else if (hay_over) begin
          ans.status = ST_HAY_BIG;
        end else if (nd_len == 0) begin
          ans.found    = 1'b1;
          ans.position = mode ? POS_W'(hay_count) : '0;
        end else if (match_seen) begin
          ans.found    = 1'b1;
          ans.position = POS_W'(match_pos);
        end
        pending_answers.push_back(ans);
        clear_haystack();
      end
    endcase
  endtask

  // send one word, with bursts and random gaps; valid stays high after acceptance
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    predict_search_word(op, b);
  endtask

  // write search_mode once all answers are out and the pipeline has drained
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode = m;
  endtask

  task automatic load_needle(input logic [7:0] b0, input logic [7:0] b1);
    send_word(OP_CLEAR, 8'($urandom));
    send_word(OP_APPEND, b0);
    send_word(OP_APPEND, b1);
  endtask

  // check each result word against the oldest answer; receiver stall pattern
  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: found=%0d position=%0d status=%0d",
                   out_found, out_position, out_status);
      end else begin
        want = pending_answers.pop_front();
        if (out_found !== want.found || out_position !== want.position ||
            out_status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected found=%0d position=%0d status=%0d, got %0d %0d %0d",
                     want.found, want.position, want.status,
                     out_found, out_position, out_status);
        end
      end
    end
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase[2];
    endcase
  end

  // empty needle: 0 in first mode, haystack length in last mode
  task automatic test_empty_needle();
    set_mode(1'b0);
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_HAY, 8'h00);
    send_word(OP_HAY, 8'hFF);
    send_word(OP_HAY, 8'h3C);
    send_word(OP_END, 8'h00);
    set_mode(1'b1);
    send_word(OP_HAY, 8'hC3);
    send_word(OP_HAY, 8'h00);
    send_word(OP_END, 8'hFF);
    send_word(OP_END, 8'h00);
  endtask

  // first and last match, overlap, nul and all-ones bytes, needle longer than haystack
  task automatic test_first_last();
    int m;
    for (m = 0; m < 2; m++) begin
      set_mode(m[0]);
      load_needle(8'h00, 8'hFF);
      send_word(OP_HAY, 8'h00);
      send_word(OP_HAY, 8'hFF);
      send_word(OP_HAY, 8'h00);
      send_word(OP_HAY, 8'hFF);
      send_word(OP_END, 8'h5A);
      load_needle(8'hAA, 8'hAA);
      send_word(OP_HAY, 8'hAA);
      send_word(OP_HAY, 8'hAA);
      send_word(OP_HAY, 8'hAA);
      send_word(OP_END, 8'hA5);
    end
    send_word(OP_APPEND, 8'h55);
    send_word(OP_HAY, 8'hAA);
    send_word(OP_HAY, 8'hAA);
    send_word(OP_END, 8'h00);
  endtask

  // appends past the needle capacity are dropped and flagged until a clear
  task automatic test_needle_overflow();
    int i;
    send_word(OP_CLEAR, 8'h00);
    for (i = 0; i < MAX_NDL + 1; i++) send_word(OP_APPEND, 8'(i));
    send_word(OP_HAY, 8'h00);
    send_word(OP_END, 8'h00);
    send_word(OP_END, 8'h00);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_APPEND, 8'h07);
    send_word(OP_HAY, 8'h07);
    send_word(OP_END, 8'h00);
  endtask

  // a needle word in the middle of a haystack restarts the haystack
  task automatic test_needle_change_midstream();
    load_needle(8'h12, 8'h34);
    send_word(OP_HAY, 8'h12);
    send_word(OP_HAY, 8'h34);
    send_word(OP_APPEND, 8'h56);
    send_word(OP_HAY, 8'h12);
    send_word(OP_HAY, 8'h34);
    send_word(OP_HAY, 8'h56);
    send_word(OP_END, 8'h00);
    send_word(OP_HAY, 8'h12);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_END, 8'h00);
  endtask

  // mode changes between matches of one haystack
  task automatic test_mode_change_midstream();
    set_mode(1'b0);
    load_needle(8'h78, 8'h79);
    send_word(OP_HAY, 8'h78);
    send_word(OP_HAY, 8'h79);
    set_mode(1'b1);
    send_word(OP_HAY, 8'h78);
    send_word(OP_HAY, 8'h79);
    send_word(OP_END, 8'h00);
    send_word(OP_HAY, 8'h78);
    send_word(OP_HAY, 8'h79);
    send_word(OP_HAY, 8'h78);
    send_word(OP_HAY, 8'h79);
    set_mode(1'b0);
    send_word(OP_HAY, 8'h78);
    send_word(OP_HAY, 8'h79);
    send_word(OP_END, 8'h00);
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_HAY, 8'h01);
    set_mode(1'b1);
    send_word(OP_END, 8'h00);
  endtask

  // one search: mostly a needle and a short haystack drawn from its bytes, some noise
  task automatic random_search();
    int         count, plant_at, i, j;
    logic [7:0] letters [0:2];
    logic [7:0] pick;
    if ($urandom_range(0, 9) == 0) begin
      count = $urandom_range(1, 6);
      for (i = 0; i < count; i++) send_word(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      if ($urandom_range(0, 5) == 0) set_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) begin
        for (i = 0; i < 3; i++) letters[i] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) letters[0] = 8'h00;
        if ($urandom_range(0, 3) == 0) letters[1] = 8'hFF;
        if ($urandom_range(0, 4) != 0) send_word(OP_CLEAR, 8'($urandom));
        count = $urandom_range(0, 19);
        if (count == 0)     count = $urandom_range(MAX_NDL + 1, MAX_NDL + 2);
        else if (count < 3) count = $urandom_range(6, MAX_NDL);
        else                count = $urandom_range(0, 5);
        for (i = 0; i < count; i++) send_word(OP_APPEND, letters[$urandom_range(0, 2)]);
      end
      count    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
      plant_at = (count > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, count - 1) : -1;
      for (i = 0; i < count; i++) begin
        if (i == plant_at)
          for (j = 0; j < nd_len; j++) send_word(OP_HAY, nd_bytes[j]);
        if ($urandom_range(0, 39) == 0) begin
          send_word($urandom_range(0, 1) ? OP_APPEND : OP_CLEAR, 8'($urandom));
        end else begin
          pick = (nd_len > 0 && $urandom_range(0, 3) != 0) ?
                 nd_bytes[$urandom_range(0, nd_len - 1)] : 8'($urandom);
          send_word(OP_HAY, pick);
        end
      end
      send_word(OP_END, 8'($urandom));
    end
  endtask

  task automatic test_random_streams();
    int first_word, first_result;
    first_word   = words_sent;
    first_result = results_seen;
    while (words_sent - first_word < 400 || results_seen - first_result < 40)
      random_search();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_needle();
    test_first_last();
    test_needle_overflow();
    test_needle_change_midstream();
    test_mode_change_midstream();
    test_random_streams();
    set_mode(1'b0);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== substring_search_first_last.f =====
src/ssfl_pkg.sv
src/ssfl_needle.sv
src/ssfl_track.sv
src/substring_search_first_last.sv
bench/testbench.sv
